[design/ami_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Affine matrix inverse package
// Shared constants, row codes and the operand tables of the closed-form
// cofactor and product terms.
// ----------------------------------------------------------------------------
package ami_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int WORD_BITS_DEFAULT = 32;

   localparam int MAT_ENTRIES = 12;
   localparam int NUM_COF     = 9;
   localparam int NUM_PROD    = 12;
   localparam int NUM_LANES   = 4;

   localparam logic [1:0] ROW_FIRST = 2'd0;
   localparam logic [1:0] ROW_MID   = 2'd1;
   localparam logic [1:0] ROW_LAST  = 2'd2;

   // Cofactor k is a[CF_PA] * a[CF_PB] - a[CF_NA] * a[CF_NB], indexes r*4+c.
   localparam int CF_PA [NUM_COF] = '{5, 9, 1, 8, 0, 4, 4, 8, 0};
   localparam int CF_PB [NUM_COF] = '{10, 2, 6, 6, 10, 2, 9, 1, 5};
   localparam int CF_NA [NUM_COF] = '{9, 1, 5, 4, 8, 0, 8, 0, 4};
   localparam int CF_NB [NUM_COF] = '{6, 10, 2, 10, 2, 6, 5, 9, 1};

   // Entries forwarded past the cofactor stages: column 0, then translation.
   localparam int FR_XSEL [6] = '{0, 4, 8, 3, 7, 11};

   // Product m is x[PR_X] * cofactor[PR_C]; the first three form the
   // determinant, the rest the translation dot products of rows 0 to 2.
   localparam int PR_X [NUM_PROD] = '{0, 1, 2, 3, 4, 5, 3, 4, 5, 3, 4, 5};
   localparam int PR_C [NUM_PROD] = '{0, 1, 2, 0, 1, 2, 3, 4, 5, 6, 7, 8};

   typedef struct packed {
      logic [1:0] row;
      logic       singular;
      logic       last;
   } row_tag_type;

endpackage

[design/affine_matrix_inverse.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Affine matrix inverse
// Inverts a bordered 4x4 affine matrix in signed fixed point and returns
// the three rows of the inverse, saturated, with singular and clip flags.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake          Payload
// req      in         req_valid/stall    twelve matrix entries, WORD_BITS each
// rsp      out        rsp_valid/stall    row index, four entries, three flags
//
// Throughput is bounded by the row sequencer, which takes a new matrix only
// once it is empty or issues the last row of the one before, and which feeds
// the three rows of one matrix through the four shared divider lanes.
// Reset clears only the pipeline valid bits and the row sequencer's counter.
// A stall backs up stage by stage, and empty stages are filled while it lasts.
// ----------------------------------------------------------------------------
module affine_matrix_inverse #(
   parameter int FRAC_BITS = ami_pkg::FRAC_BITS_DEFAULT,
   parameter int WORD_BITS = ami_pkg::WORD_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [WORD_BITS-1:0] req_a_r0c0,
   input  logic signed [WORD_BITS-1:0] req_a_r0c1,
   input  logic signed [WORD_BITS-1:0] req_a_r0c2,
   input  logic signed [WORD_BITS-1:0] req_a_r0c3,
   input  logic signed [WORD_BITS-1:0] req_a_r1c0,
   input  logic signed [WORD_BITS-1:0] req_a_r1c1,
   input  logic signed [WORD_BITS-1:0] req_a_r1c2,
   input  logic signed [WORD_BITS-1:0] req_a_r1c3,
   input  logic signed [WORD_BITS-1:0] req_a_r2c0,
   input  logic signed [WORD_BITS-1:0] req_a_r2c1,
   input  logic signed [WORD_BITS-1:0] req_a_r2c2,
   input  logic signed [WORD_BITS-1:0] req_a_r2c3,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_row_index,
   output logic signed [WORD_BITS-1:0] rsp_q_c0,
   output logic signed [WORD_BITS-1:0] rsp_q_c1,
   output logic signed [WORD_BITS-1:0] rsp_q_c2,
   output logic signed [WORD_BITS-1:0] rsp_q_c3,
   output logic                        rsp_singular,
   output logic                        rsp_clipped,
   output logic                        rsp_last_row
);

   localparam int W  = WORD_BITS;
   localparam int NW = 3 * W + FRAC_BITS + 4;
   localparam int DW = 3 * W + 3;
   localparam int L  = ami_pkg::NUM_LANES;

   logic signed [W-1:0]   a_vec [ami_pkg::MAT_ENTRIES];
   logic                  fr_ready, fr_valid;
   logic signed [2*W:0]   fr_c [ami_pkg::NUM_COF];
   logic signed [3*W+2:0] fr_t [3];
   logic signed [3*W+2:0] fr_det;

   logic                  rs_valid, rs_ready;
   logic [NW-1:0]         rs_n [L];
   logic [DW-1:0]         rs_d;
   logic [L-1:0]          rs_neg;
   ami_pkg::row_tag_type  rs_tag;

   logic                  dv_valid, dv_ready, o_rdy;
   logic [W-1:0]          dv_q [L];
   logic                  dv_ovf [L];
   logic [L-1:0]          dv_neg;
   ami_pkg::row_tag_type  dv_tag;

   logic                  rsp_valid_ff;
   logic [W-1:0]          q_ff [L], q_in [L];
   logic                  clip_ff, clip_in;
   ami_pkg::row_tag_type  tag_ff;

   assign a_vec = '{req_a_r0c0, req_a_r0c1, req_a_r0c2, req_a_r0c3,
                    req_a_r1c0, req_a_r1c1, req_a_r1c2, req_a_r1c3,
                    req_a_r2c0, req_a_r2c1, req_a_r2c2, req_a_r2c3};

   ami_front #(.W(W)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (fr_ready),
      .a_in      (a_vec),
      .out_valid (fr_valid),
      .out_ready (rs_ready),
      .c_out     (fr_c),
      .t_out     (fr_t),
      .det_out   (fr_det)
   );

   ami_row_seq #(.W(W), .F(FRAC_BITS)) u_row_seq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (rs_ready),
      .c_in      (fr_c),
      .t_in      (fr_t),
      .det_in    (fr_det),
      .out_valid (rs_valid),
      .out_ready (dv_ready),
      .n_out     (rs_n),
      .d_out     (rs_d),
      .neg_out   (rs_neg),
      .tag_out   (rs_tag)
   );

   ami_div #(.W(W), .NW(NW), .DW(DW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rs_valid),
      .in_ready  (dv_ready),
      .n_in      (rs_n),
      .d_in      (rs_d),
      .neg_in    (rs_neg),
      .tag_in    (rs_tag),
      .out_valid (dv_valid),
      .out_ready (o_rdy),
      .q_out     (dv_q),
      .ovf_out   (dv_ovf),
      .neg_out   (dv_neg),
      .tag_out   (dv_tag)
   );

   assign req_stall = !fr_ready;
   assign o_rdy     = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      logic lane_clip;
      logic [W-1:0] lim;
      lim     = W'(1) << (W - 1);
      clip_in = 1'b0;
      for (int j = 0; j < L; j++) begin
         if (dv_neg[j]) begin
            lane_clip = dv_ovf[j] || (dv_q[j] > lim);
            q_in[j]   = lane_clip ? lim : W'(-dv_q[j]);
         end else begin
            lane_clip = dv_ovf[j] || dv_q[j][W-1];
            q_in[j]   = lane_clip ? lim - W'(1) : dv_q[j];
         end
         if (dv_tag.singular) begin
            lane_clip = 1'b0;
            q_in[j]   = '0;
         end
         clip_in = clip_in | lane_clip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (o_rdy) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (o_rdy) begin
         q_ff    <= q_in;
         clip_ff <= clip_in;
         tag_ff  <= dv_tag;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_row_index = tag_ff.row;
   assign rsp_q_c0      = q_ff[0];
   assign rsp_q_c1      = q_ff[1];
   assign rsp_q_c2      = q_ff[2];
   assign rsp_q_c3      = q_ff[3];
   assign rsp_singular  = tag_ff.singular;
   assign rsp_clipped   = clip_ff;
   assign rsp_last_row  = tag_ff.last;

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_row_index == ami_pkg::ROW_FIRST ||
                     rsp_row_index == ami_pkg::ROW_MID ||
                     rsp_row_index == ami_pkg::ROW_LAST))
      else $error("row index out of range");

   a_last_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_row == (rsp_row_index == ami_pkg::ROW_LAST)))
      else $error("last row flag does not match row index");

   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_singular) |-> (rsp_q_c0 == '0 && rsp_q_c1 == '0 &&
                                       rsp_q_c2 == '0 && rsp_q_c3 == '0 &&
                                       !rsp_clipped))
      else $error("singular row is not all zero");

   a_row_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_row_index == ami_pkg::ROW_FIRST) |=>
      (!rsp_valid || rsp_row_index == ami_pkg::ROW_MID))
      else $error("row following the first row is out of order");

endmodule

[design/ami_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Affine matrix inverse front end
// Five pipeline stages that form the cofactors, the determinant and the
// three translation dot products of one matrix.
// ----------------------------------------------------------------------------
module ami_front #(
   parameter int W = ami_pkg::WORD_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic signed [W-1:0]   a_in [ami_pkg::MAT_ENTRIES],
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic signed [2*W:0]   c_out [ami_pkg::NUM_COF],
   output logic signed [3*W+2:0] t_out [3],
   output logic signed [3*W+2:0] det_out
);

   localparam int CW  = 2 * W + 1;
   localparam int PLW = 2 * W + 2;
   localparam int PHW = 2 * W;
   localparam int PW  = 3 * W + 1;
   localparam int SW  = 3 * W + 3;

   logic [4:0] vld_ff;
   logic [5:0] rdy;

   logic signed [2*W-1:0] pp_ff [9], pp_in [9];
   logic signed [2*W-1:0] pn_ff [9], pn_in [9];
   logic signed [W-1:0]   x1_ff [6], x2_ff [6];
   logic signed [CW-1:0]  c2_ff [9], c2_in [9];
   logic signed [CW-1:0]  c3_ff [9], c4_ff [9], c5_ff [9];
   logic signed [PLW-1:0] pl_ff [12], pl_in [12];
   logic signed [PHW-1:0] ph_ff [12], ph_in [12];
   logic signed [PW-1:0]  p4_ff [12], p4_in [12];
   logic signed [SW-1:0]  t_ff [3], t_in [3];
   logic signed [SW-1:0]  det_ff, det_in;

   assign rdy[5] = out_ready;
   genvar s;
   for (s = 0; s < 5; s++) begin : g_rdy
      assign rdy[s] = !vld_ff[s] || rdy[s+1];
   end
   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[4];

   always_comb begin
      logic signed [W-1:0] hi;
      logic        [W:0]   lo;
      logic signed [W-1:0] x;
      for (int k = 0; k < 9; k++) begin
         pp_in[k] = $signed({{W{a_in[CF_IDX(0, k)][W-1]}}, a_in[CF_IDX(0, k)]})
                  * $signed({{W{a_in[CF_IDX(1, k)][W-1]}}, a_in[CF_IDX(1, k)]});
         pn_in[k] = $signed({{W{a_in[CF_IDX(2, k)][W-1]}}, a_in[CF_IDX(2, k)]})
                  * $signed({{W{a_in[CF_IDX(3, k)][W-1]}}, a_in[CF_IDX(3, k)]});
         c2_in[k] = $signed({pp_ff[k][2*W-1], pp_ff[k]})
                  - $signed({pn_ff[k][2*W-1], pn_ff[k]});
      end
      for (int m = 0; m < 12; m++) begin
         x  = x2_ff[ami_pkg::PR_X[m]];
         lo = c2_ff[ami_pkg::PR_C[m]][W:0];
         hi = c2_ff[ami_pkg::PR_C[m]][2*W:W+1];
         pl_in[m] = $signed({{(W+2){x[W-1]}}, x}) * $signed({{(W+1){1'b0}}, lo});
         ph_in[m] = $signed({{W{x[W-1]}}, x}) * $signed({{W{hi[W-1]}}, hi});
         p4_in[m] = ($signed({{(W+1){ph_ff[m][PHW-1]}}, ph_ff[m]}) <<< (W + 1))
                  + $signed({{(W-1){pl_ff[m][PLW-1]}}, pl_ff[m]});
      end
      det_in = $signed({{2{p4_ff[0][PW-1]}}, p4_ff[0]})
             + $signed({{2{p4_ff[1][PW-1]}}, p4_ff[1]})
             + $signed({{2{p4_ff[2][PW-1]}}, p4_ff[2]});
      for (int r = 0; r < 3; r++) begin
         t_in[r] = $signed({{2{p4_ff[3*r+3][PW-1]}}, p4_ff[3*r+3]})
                 + $signed({{2{p4_ff[3*r+4][PW-1]}}, p4_ff[3*r+4]})
                 + $signed({{2{p4_ff[3*r+5][PW-1]}}, p4_ff[3*r+5]});
      end
   end

   function automatic int CF_IDX(input int sel, input int k);
      int r;
      case (sel)
         0:       r = ami_pkg::CF_PA[k];
         1:       r = ami_pkg::CF_PB[k];
         2:       r = ami_pkg::CF_NA[k];
         default: r = ami_pkg::CF_NB[k];
      endcase
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (rdy[0]) vld_ff[0] <= in_valid;
         for (int i = 1; i < 5; i++) begin
            if (rdy[i]) vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         pp_ff <= pp_in;
         pn_ff <= pn_in;
         for (int i = 0; i < 6; i++) x1_ff[i] <= a_in[ami_pkg::FR_XSEL[i]];
      end
      if (rdy[1]) begin
         c2_ff <= c2_in;
         x2_ff <= x1_ff;
      end
      if (rdy[2]) begin
         pl_ff <= pl_in;
         ph_ff <= ph_in;
         c3_ff <= c2_ff;
      end
      if (rdy[3]) begin
         p4_ff <= p4_in;
         c4_ff <= c3_ff;
      end
      if (rdy[4]) begin
         det_ff <= det_in;
         t_ff   <= t_in;
         c5_ff  <= c4_ff;
      end
   end

   assign c_out   = c5_ff;
   assign t_out   = t_ff;
   assign det_out = det_ff;

endmodule

[design/ami_row_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Affine matrix inverse row sequencer
// Holds one matrix's terms and issues its three rows, one per cycle unless
// stalled, as magnitude numerators, a magnitude divisor and quotient signs.
// ----------------------------------------------------------------------------
module ami_row_seq #(
   parameter int W = ami_pkg::WORD_BITS_DEFAULT,
   parameter int F = ami_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic signed [2*W:0]         c_in [ami_pkg::NUM_COF],
   input  logic signed [3*W+2:0]       t_in [3],
   input  logic signed [3*W+2:0]       det_in,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [3*W+F+3:0]            n_out [ami_pkg::NUM_LANES],
   output logic [3*W+2:0]              d_out,
   output logic [ami_pkg::NUM_LANES-1:0] neg_out,
   output ami_pkg::row_tag_type        tag_out
);

   localparam int CW = 2 * W + 1;
   localparam int SW = 3 * W + 3;
   localparam int NW = 3 * W + F + 4;

   logic                 hv_ff, hv_in;
   logic [1:0]           cnt_ff, cnt_in;
   logic signed [CW-1:0] c_ff [9];
   logic signed [SW-1:0] t_ff [3];
   logic signed [SW-1:0] det_ff;

   logic                 ov_ff;
   logic [NW-1:0]        n_ff [ami_pkg::NUM_LANES], n_in [ami_pkg::NUM_LANES];
   logic [SW-1:0]        d_ff, d_in;
   logic [ami_pkg::NUM_LANES-1:0] neg_ff, neg_in;
   ami_pkg::row_tag_type tag_ff, tag_in;

   logic o_rdy, emit, last, take;
   logic signed [CW-1:0] crow [3];
   logic signed [SW-1:0] trow;

   always_comb begin
      logic signed [NW-1:0] n [ami_pkg::NUM_LANES];
      o_rdy    = !ov_ff || out_ready;
      emit     = hv_ff && o_rdy;
      last     = (cnt_ff == ami_pkg::ROW_LAST);
      in_ready = !hv_ff || (emit && last);
      take     = in_valid && in_ready;
      hv_in    = take ? 1'b1 : ((emit && last) ? 1'b0 : hv_ff);
      cnt_in   = take ? ami_pkg::ROW_FIRST : (emit ? cnt_ff + 2'd1 : cnt_ff);

      case (cnt_ff)
         ami_pkg::ROW_FIRST: begin
            crow = '{c_ff[0], c_ff[1], c_ff[2]};
            trow = t_ff[0];
         end
         ami_pkg::ROW_MID: begin
            crow = '{c_ff[3], c_ff[4], c_ff[5]};
            trow = t_ff[1];
         end
         default: begin
            crow = '{c_ff[6], c_ff[7], c_ff[8]};
            trow = t_ff[2];
         end
      endcase

      for (int j = 0; j < 3; j++) begin
         n[j] = $signed({{(NW-CW){crow[j][CW-1]}}, crow[j]}) <<< (2 * F);
      end
      n[3] = (-$signed({{(NW-SW){trow[SW-1]}}, trow})) <<< F;
      for (int j = 0; j < ami_pkg::NUM_LANES; j++) begin
         n_in[j]   = n[j][NW-1] ? NW'(-n[j]) : NW'(n[j]);
         neg_in[j] = n[j][NW-1] ^ det_ff[SW-1];
      end
      d_in            = det_ff[SW-1] ? SW'(-det_ff) : SW'(det_ff);
      tag_in.row      = cnt_ff;
      tag_in.singular = (det_ff == '0);
      tag_in.last     = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hv_ff  <= 1'b0;
         cnt_ff <= ami_pkg::ROW_FIRST;
         ov_ff  <= 1'b0;
      end else begin
         hv_ff  <= hv_in;
         cnt_ff <= cnt_in;
         if (o_rdy) ov_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         c_ff   <= c_in;
         t_ff   <= t_in;
         det_ff <= det_in;
      end
      if (emit) begin
         n_ff   <= n_in;
         d_ff   <= d_in;
         neg_ff <= neg_in;
         tag_ff <= tag_in;
      end
   end

   assign out_valid = ov_ff;
   assign n_out     = n_ff;
   assign d_out     = d_ff;
   assign neg_out   = neg_ff;
   assign tag_out   = tag_ff;

endmodule

[design/ami_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Affine matrix inverse divider
// Four restoring divider lanes in lockstep, one overflow check stage and
// one quotient bit per stage, with a shared valid chain.
// ----------------------------------------------------------------------------
module ami_div #(
   parameter int W  = ami_pkg::WORD_BITS_DEFAULT,
   parameter int NW = 3 * W + 20,
   parameter int DW = 3 * W + 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [NW-1:0]                 n_in [ami_pkg::NUM_LANES],
   input  logic [DW-1:0]                 d_in,
   input  logic [ami_pkg::NUM_LANES-1:0] neg_in,
   input  ami_pkg::row_tag_type          tag_in,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [W-1:0]                  q_out [ami_pkg::NUM_LANES],
   output logic                          ovf_out [ami_pkg::NUM_LANES],
   output logic [ami_pkg::NUM_LANES-1:0] neg_out,
   output ami_pkg::row_tag_type          tag_out
);

   localparam int NS = W + 1;
   localparam int RW = DW + W + 1;
   localparam int L  = ami_pkg::NUM_LANES;

   logic [NS-1:0] vld_ff, vin;
   logic [NS:0]   rdy;

   logic [RW-1:0] rem_ff [NS][L], rem_in [NS][L];
   logic [W-1:0]  q_ff [NS][L], q_in [NS][L];
   logic          ovf_ff [NS][L], ovf_in [NS][L];
   logic [L-1:0]  neg_ff [NS], neg_sin [NS];
   logic [DW-1:0] d_ff [NS], d_sin [NS];
   ami_pkg::row_tag_type tag_ff [NS], tag_sin [NS];

   assign rdy[NS]  = out_ready;
   assign in_ready = rdy[0];
   assign vin      = {vld_ff[NS-2:0], in_valid};

   genvar s, l;
   for (s = 0; s < NS; s++) begin : g_st
      assign rdy[s] = !vld_ff[s] || rdy[s+1];
      if (s == 0) begin : g_first
         assign neg_sin[s] = neg_in;
         assign d_sin[s]   = d_in;
         assign tag_sin[s] = tag_in;
         for (l = 0; l < L; l++) begin : g_ln
            logic [RW-1:0] nx, dsh;
            assign nx            = {{(RW-NW){1'b0}}, n_in[l]};
            assign dsh           = {1'b0, d_in, {W{1'b0}}};
            assign rem_in[s][l]  = nx;
            assign q_in[s][l]    = '0;
            assign ovf_in[s][l]  = (nx >= dsh);
         end
      end else begin : g_step
         assign neg_sin[s] = neg_ff[s-1];
         assign d_sin[s]   = d_ff[s-1];
         assign tag_sin[s] = tag_ff[s-1];
         for (l = 0; l < L; l++) begin : g_ln
            logic [RW-1:0] dsh;
            logic          ge;
            assign dsh          = {{(RW-DW){1'b0}}, d_ff[s-1]} << (W - s);
            assign ge           = (rem_ff[s-1][l] >= dsh);
            assign rem_in[s][l] = ge ? rem_ff[s-1][l] - dsh : rem_ff[s-1][l];
            assign q_in[s][l]   = q_ff[s-1][l] | (ge ? (W'(1) << (W - s)) : W'(0));
            assign ovf_in[s][l] = ovf_ff[s-1][l];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (rdy[s]) begin
            vld_ff[s] <= vin[s];
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[s]) begin
            rem_ff[s] <= rem_in[s];
            q_ff[s]   <= q_in[s];
            ovf_ff[s] <= ovf_in[s];
            neg_ff[s] <= neg_sin[s];
            d_ff[s]   <= d_sin[s];
            tag_ff[s] <= tag_sin[s];
         end
      end
   end

   assign out_valid = vld_ff[NS-1];
   assign q_out     = q_ff[NS-1];
   assign ovf_out   = ovf_ff[NS-1];
   assign neg_out   = neg_ff[NS-1];
   assign tag_out   = tag_ff[NS-1];

endmodule

[tb/tb_affine_matrix_inverse.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Affine matrix inverse testbench
// Drives bordered affine matrices into the inverter and checks every row of
// the inverse against a wide-integer prediction of cofactors, determinant,
// truncating division and saturation, under several idle and stall phases.
// ----------------------------------------------------------------------------
module tb_affine_matrix_inverse;

   localparam int FB = ami_pkg::FRAC_BITS_DEFAULT;
   localparam int WB = ami_pkg::WORD_BITS_DEFAULT;
   localparam int LIMIT_CYCLES = 400000;

   typedef logic signed [WB-1:0] word_type;
   typedef logic signed [255:0] wide_type;

   typedef struct {
      word_type e [ami_pkg::MAT_ENTRIES];
   } matrix_type;

   typedef struct {
      logic [1:0] row;
      word_type   q [4];
      logic       singular;
      logic       clipped;
      logic       last;
   } inv_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_stall_q = 1'b0;
   word_type req_e [ami_pkg::MAT_ENTRIES];
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_row_index;
   word_type rsp_q_c0, rsp_q_c1, rsp_q_c2, rsp_q_c3;
   logic rsp_singular, rsp_clipped, rsp_last_row;

   matrix_type  pending_matrices [$];
   inv_row_type expected_rows [$];
   int errors = 0;
   int cycles = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_off = 0;

   initial begin
      foreach (req_e[i]) req_e[i] = '0;
   end

   affine_matrix_inverse dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_a_r0c0(req_e[0]), .req_a_r0c1(req_e[1]), .req_a_r0c2(req_e[2]),
      .req_a_r0c3(req_e[3]), .req_a_r1c0(req_e[4]), .req_a_r1c1(req_e[5]),
      .req_a_r1c2(req_e[6]), .req_a_r1c3(req_e[7]), .req_a_r2c0(req_e[8]),
      .req_a_r2c1(req_e[9]), .req_a_r2c2(req_e[10]), .req_a_r2c3(req_e[11]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_row_index(rsp_row_index),
      .rsp_q_c0(rsp_q_c0), .rsp_q_c1(rsp_q_c1), .rsp_q_c2(rsp_q_c2),
      .rsp_q_c3(rsp_q_c3), .rsp_singular(rsp_singular),
      .rsp_clipped(rsp_clipped), .rsp_last_row(rsp_last_row)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic word_type divide_saturate(wide_type num, wide_type den,
                                                ref logic clip);
      wide_type quo;
      wide_type hi;
      wide_type lo;
      quo = num / den;
      hi = (wide_type'(1) <<< (WB - 1)) - 1;
      lo = -(wide_type'(1) <<< (WB - 1));
      if (quo > hi) begin
         clip = 1'b1;
         quo = hi;
      end else if (quo < lo) begin
         clip = 1'b1;
         quo = lo;
      end
      return word_type'(quo[WB-1:0]);
   endfunction

   task automatic predict_inverse(matrix_type m);
      wide_type a [3][3];
      wide_type v [3];
      wide_type adj [3][3];
      wide_type det;
      wide_type t;
      inv_row_type r;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) a[i][j] = wide_type'(m.e[i*4+j]);
         v[i] = wide_type'(m.e[i*4+3]);
      end
      adj[0][0] = a[1][1]*a[2][2] - a[2][1]*a[1][2];
      adj[0][1] = a[2][1]*a[0][2] - a[0][1]*a[2][2];
      adj[0][2] = a[0][1]*a[1][2] - a[1][1]*a[0][2];
      adj[1][0] = a[2][0]*a[1][2] - a[1][0]*a[2][2];
      adj[1][1] = a[0][0]*a[2][2] - a[2][0]*a[0][2];
      adj[1][2] = a[1][0]*a[0][2] - a[0][0]*a[1][2];
      adj[2][0] = a[1][0]*a[2][1] - a[2][0]*a[1][1];
      adj[2][1] = a[2][0]*a[0][1] - a[0][0]*a[2][1];
      adj[2][2] = a[0][0]*a[1][1] - a[1][0]*a[0][1];
      det = a[0][0]*adj[0][0] + a[1][0]*adj[0][1] + a[2][0]*adj[0][2];
      for (int i = 0; i < 3; i++) begin
         r.row = 2'(i);
         r.singular = (det == 0);
         r.clipped = 1'b0;
         r.last = (r.row == ami_pkg::ROW_LAST);
         if (r.singular) begin
            foreach (r.q[k]) r.q[k] = '0;
         end else begin
            t = adj[i][0]*v[0] + adj[i][1]*v[1] + adj[i][2]*v[2];
            for (int j = 0; j < 3; j++)
               r.q[j] = divide_saturate(adj[i][j] <<< (2*FB), det, r.clipped);
            r.q[3] = divide_saturate((-t) <<< FB, det, r.clipped);
         end
         expected_rows.push_back(r);
      end
   endtask

   task automatic report_mismatch(string what, longint got, longint want);
      errors++;
      $display("mismatch %s: got %0h expected %0h", what, got, want);
   endtask

   // Driver: the valid stays high across back-to-back transactions.
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || (req_valid && !req_stall_q)) begin
            if (pending_matrices.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               matrix_type m;
               m = pending_matrices.pop_front();
               predict_inverse(m);
               foreach (req_e[i]) req_e[i] <= m.e[i];
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= (hold_off > 0) || ($urandom_range(99) < recv_stall_pct);
      end
   end

   // The stall is sampled at the rising edge so that the driver sees acceptance.
   always @(posedge clock) req_stall_q <= req_stall;

   always @(posedge clock) begin
      if (hold_off > 0) hold_off <= hold_off - 1;
   end

   // Monitor.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rows.size() == 0) begin
            report_mismatch("unexpected row", rsp_row_index, 0);
         end else begin
            inv_row_type e;
            e = expected_rows.pop_front();
            if (rsp_row_index !== e.row) report_mismatch("row_index", rsp_row_index, e.row);
            if (rsp_q_c0 !== e.q[0]) report_mismatch("q_c0", rsp_q_c0, e.q[0]);
            if (rsp_q_c1 !== e.q[1]) report_mismatch("q_c1", rsp_q_c1, e.q[1]);
            if (rsp_q_c2 !== e.q[2]) report_mismatch("q_c2", rsp_q_c2, e.q[2]);
            if (rsp_q_c3 !== e.q[3]) report_mismatch("q_c3", rsp_q_c3, e.q[3]);
            if (rsp_singular !== e.singular)
               report_mismatch("singular", rsp_singular, e.singular);
            if (rsp_clipped !== e.clipped) report_mismatch("clipped", rsp_clipped, e.clipped);
            if (rsp_last_row !== e.last) report_mismatch("last_row", rsp_last_row, e.last);
         end
      end
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout with %0d rows outstanding", expected_rows.size());
         $display("** affine_matrix_inverse: FAILED **");
         $finish;
      end
   end

   function automatic word_type random_entry();
      case ($urandom_range(5))
         0: return word_type'($urandom);
         1: return word_type'($signed($urandom_range(2 << FB)) - (1 << FB));
         2: return word_type'($urandom_range(1)) <<< FB;
         3: return word_type'($urandom_range(3) ? 32'sh7fffffff : 32'sh80000000);
         default: return word_type'($signed($urandom_range(16 << FB)) - (8 << FB));
      endcase
   endfunction

   function automatic matrix_type random_matrix();
      matrix_type m;
      foreach (m.e[i]) m.e[i] = random_entry();
      // Some matrices are diagonal-heavy so most inverses stay in range.
      if ($urandom_range(2) == 0) begin
         foreach (m.e[i]) if (i % 4 != 3 && i / 4 != i % 4) m.e[i] = m.e[i] >>> 8;
      end
      if ($urandom_range(9) == 0) m.e[8 + $urandom_range(2)] = '0;
      if ($urandom_range(9) == 0) begin
         for (int c = 0; c < 3; c++) m.e[8+c] = m.e[c];
      end
      return m;
   endfunction

   function automatic matrix_type diag_matrix(word_type d0, word_type d1, word_type d2,
                                              word_type t);
      matrix_type m;
      foreach (m.e[i]) m.e[i] = '0;
      m.e[0] = d0; m.e[5] = d1; m.e[10] = d2;
      m.e[3] = t; m.e[7] = -t; m.e[11] = t;
      return m;
   endfunction

   task automatic wait_drained();
      while (pending_matrices.size() > 0 || req_valid || expected_rows.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      matrix_type m;
      word_type one;
      one = word_type'(1) <<< FB;
      repeat (10) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      pending_matrices.push_back(diag_matrix(one, one, one, '0));
      pending_matrices.push_back(diag_matrix(one, one, one, 32'sh7fffffff));
      pending_matrices.push_back(diag_matrix(2 * one, -one, one >>> 1, one));
      pending_matrices.push_back(diag_matrix(32'sh7fffffff, 32'sh7fffffff,
                                             32'sh7fffffff, 32'sh80000000));
      pending_matrices.push_back(diag_matrix(32'sh80000000, 32'sh80000000,
                                             32'sh80000000, 32'sh7fffffff));
      pending_matrices.push_back(diag_matrix(32'sh1, 32'sh1, 32'sh1, one));
      pending_matrices.push_back(diag_matrix(32'sh1, one, one, 32'sh80000000));
      pending_matrices.push_back(diag_matrix(-32'sh3, one, 32'sh7, -32'sh5));
      pending_matrices.push_back(diag_matrix('0, one, one, one));
      foreach (m.e[i]) m.e[i] = '0;
      pending_matrices.push_back(m);
      foreach (m.e[i]) m.e[i] = '1;
      pending_matrices.push_back(m);
      foreach (m.e[i]) m.e[i] = (i % 2) ? 32'sh80000000 : 32'sh7fffffff;
      pending_matrices.push_back(m);
      foreach (m.e[i]) m.e[i] = 32'sh55555555 ^ ((i % 2) ? '1 : '0);
      pending_matrices.push_back(m);
      foreach (m.e[i]) m.e[i] = word_type'((i * 7 + 3) << FB) - 5 * one;
      pending_matrices.push_back(m);
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1 || phase == 3) ? 72 : 0;
         recv_stall_pct = (phase == 2) ? 72 : (phase == 3) ? 27 : 0;
         if (phase == 3) send_idle_pct = 27;
         for (int n = 0; n < 50; n++) pending_matrices.push_back(random_matrix());
         if (phase == 0) hold_off = 300;
         wait_drained();
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;

      repeat (WB + 40) @(posedge clock);
      if (errors == 0) begin
         $display("** affine_matrix_inverse: PASSED **");
      end else begin
         $display("** affine_matrix_inverse: FAILED **");
      end
      $finish;
   end

endmodule
